@@ src/generation_handle_slot_allocator_top_macros.svh @@
// Assertion helpers for the slot allocator top level.
`ifndef GENERATION_HANDLE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define GENERATION_HANDLE_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GHSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GHSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ghsa_pkg.sv @@
package ghsa_pkg;

  localparam int SLOTS      = 1024;
  localparam int GEN_SHIFT  = 12;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int PTR_W      = IDX_W + 1;
  localparam int HANDLE_W   = 31;
  localparam int SLOT_OUT_W = 10;
  localparam int RUN_W      = 32;

  // Null link / no current slot
  localparam logic [PTR_W-1:0] NIL     = PTR_W'(SLOTS);
  localparam logic [31:0]      GEN_INC = 32'(1) << GEN_SHIFT;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_RUN    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // One slot record; live=0 means free
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                live;
    logic [HANDLE_W-1:0] parent;
    logic [RUN_W-1:0]    runs;
    logic [PTR_W-1:0]    next;
  } slot_rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_rec_t        wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    slot;
    logic                found;
  } result_t;

endpackage

@@ src/generation_handle_slot_allocator_top.sv @@
// Generation-tagged slot allocator: hands out handles {generation, slot index}.
// Command channel: drive mode/handle/parent_handle/check_permission with start;
//   the command transfers on a rising edge where start=1 and busy=0.
// Modes: allocate (pop free-list head), free (push by handle index), lookup
//   (handle 0 = current slot), run (make slot current, count runs).
// Result channel: done pulses for one cycle with status, result_handle,
//   result_slot and found_valid; the receiver has no way to stall it, the
//   transfer happens at the edge that ends the done cycle.
// done is registered from the result that the EXEC state computes.
// Commands do not overlap: busy covers the cycle in which the slot record
//   is read from the slot RAM and written back.
// Reset (rst, synchronous): a clearing pass walks all 1024 RAM entries, one
//   per cycle, zeroing handles, marking slots free and linking each entry to
//   the next; busy stays high until the pass is done.
// The only slot ever in the running state is the current one, so the RAM
//   keeps a live bit per slot and the current slot/handle live in registers.
module generation_handle_slot_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [ghsa_pkg::HANDLE_W-1:0] handle,
  input  logic [ghsa_pkg::HANDLE_W-1:0] parent_handle,
  input  logic                          check_permission,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [ghsa_pkg::HANDLE_W-1:0] result_handle,
  output logic [ghsa_pkg::SLOT_OUT_W-1:0] result_slot,
  output logic                          found_valid
);

  `include "generation_handle_slot_allocator_top_macros.svh"

  ghsa_pkg::ram_req_t  ram_req;
  ghsa_pkg::slot_rec_t rdata;
  ghsa_pkg::result_t   res;

  // Controller: command latch, free list head, current slot, record update
  ghsa_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .mode             (mode),
    .handle           (handle),
    .parent_handle    (parent_handle),
    .check_permission (check_permission),
    .rdata            (rdata),
    .busy             (busy),
    .ram_req          (ram_req),
    .res              (res)
  );

  // Slot records: handle, live bit, parent, run count, free-list link
  ghsa_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Result register: decouples the output strobe from the RAM read path
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status        <= res.status;
      result_handle <= res.handle;
      result_slot   <= ghsa_pkg::SLOT_OUT_W'(res.slot);
      found_valid   <= res.found;
    end
  end

  // A result always follows a command transfer, via the EXEC state and the done register
  `GHSA_ASSERT_IMP(a_done_after_cmd, done, $past(start && !busy, 2), "done without a command")
  // A transfer makes the block busy for the record update
  `GHSA_ASSERT_NXT(a_busy_after_cmd, start && !busy, busy, "command did not raise busy")
  // Error results carry no slot
  `GHSA_ASSERT_IMP(a_err_empty, done && status != ghsa_pkg::STAT_OK,
                   !found_valid && result_handle == '0 && result_slot == '0,
                   "error result carries slot data")
  // The block is ready again while the result is shown
  `GHSA_ASSERT_IMP(a_ready_on_done, done, !busy, "busy during result cycle")

endmodule

@@ src/ghsa_slot_ram.sv @@
module ghsa_slot_ram (
  input  logic                clk,
  input  ghsa_pkg::ram_req_t  req,
  output ghsa_pkg::slot_rec_t rdata
);

  ghsa_pkg::slot_rec_t mem [ghsa_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ src/ghsa_ctrl.sv @@
module ghsa_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         mode,
  input  logic [ghsa_pkg::HANDLE_W-1:0]      handle,
  input  logic [ghsa_pkg::HANDLE_W-1:0]      parent_handle,
  input  logic                               check_permission,
  input  ghsa_pkg::slot_rec_t                rdata,
  output logic                               busy,
  output ghsa_pkg::ram_req_t                 ram_req,
  output ghsa_pkg::result_t                  res
);

  localparam int IW = ghsa_pkg::IDX_W;
  localparam int PW = ghsa_pkg::PTR_W;
  localparam int HW = ghsa_pkg::HANDLE_W;

  ghsa_pkg::fsm_t state, state_next;

  logic [PW-1:0] clr_idx;
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] cur_slot, cur_slot_next;
  logic [HW-1:0] cur_handle, cur_handle_next;

  ghsa_pkg::mode_t op_mode;
  logic [HW-1:0]   op_handle;
  logic [HW-1:0]   op_parent;
  logic            op_perm;
  logic [PW-1:0]   op_slot;

  logic            accept;
  logic [IW-1:0]   s;
  logic            hit;
  logic            cur_is_s;
  logic [31:0]     gen_sum;
  logic [31:0]     gen;
  logic [HW-1:0]   new_handle;

  assign accept = (state == ghsa_pkg::FSM_IDLE) && start;
  assign busy   = (state != ghsa_pkg::FSM_IDLE);
  assign s      = op_slot[IW-1:0];
  assign hit    = rdata.live && (rdata.handle == op_handle);
  assign cur_is_s = (cur_slot == op_slot);

  // next generation: bump, clear index bits, restart on zero or sign bit
  always_comb begin
    gen_sum = {1'b0, rdata.handle} + ghsa_pkg::GEN_INC;
    gen     = {gen_sum[31:IW], IW'(0)};
    if (gen == 32'd0 || gen[31]) begin
      gen = ghsa_pkg::GEN_INC;
    end
    new_handle = {gen[30:IW], s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ghsa_pkg::FSM_CLEAR;
      clr_idx    <= '0;
      free_head  <= '0;
      cur_slot   <= ghsa_pkg::NIL;
      cur_handle <= '0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      cur_slot   <= cur_slot_next;
      cur_handle <= cur_handle_next;
      if (state == ghsa_pkg::FSM_CLEAR) begin
        clr_idx <= clr_idx + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode   <= ghsa_pkg::mode_t'(mode);
      op_handle <= handle;
      op_parent <= parent_handle;
      op_perm   <= check_permission;
      op_slot   <= (ghsa_pkg::mode_t'(mode) == ghsa_pkg::MODE_ALLOC) ? free_head
                                                                     : {1'b0, handle[IW-1:0]};
    end
  end

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    cur_slot_next   = cur_slot;
    cur_handle_next = cur_handle;
    ram_req         = '0;
    res             = '0;
    res.status      = ghsa_pkg::STAT_OK;

    if (state == ghsa_pkg::FSM_IDLE) begin
      ram_req.raddr = (ghsa_pkg::mode_t'(mode) == ghsa_pkg::MODE_ALLOC) ? free_head[IW-1:0]
                                                                       : handle[IW-1:0];
    end else begin
      ram_req.raddr = s;
    end

    unique case (state)
      ghsa_pkg::FSM_CLEAR: begin
        ram_req.we           = 1'b1;
        ram_req.waddr        = clr_idx[IW-1:0];
        ram_req.wdata.handle = '0;
        ram_req.wdata.live   = 1'b0;
        ram_req.wdata.parent = '0;
        ram_req.wdata.runs   = '0;
        ram_req.wdata.next   = clr_idx + PW'(1);
        if (clr_idx == PW'(ghsa_pkg::SLOTS - 1)) begin
          state_next = ghsa_pkg::FSM_IDLE;
        end
      end
      ghsa_pkg::FSM_IDLE: begin
        if (accept) begin
          state_next = ghsa_pkg::FSM_EXEC;
        end
      end
      ghsa_pkg::FSM_EXEC: begin
        state_next    = ghsa_pkg::FSM_IDLE;
        res.valid     = 1'b1;
        ram_req.waddr = s;
        ram_req.wdata = rdata;
        unique case (op_mode)
          ghsa_pkg::MODE_ALLOC: begin
            if (op_slot == ghsa_pkg::NIL) begin
              res.status = ghsa_pkg::STAT_FULL;
            end else begin
              ram_req.we           = 1'b1;
              ram_req.wdata.handle = new_handle;
              ram_req.wdata.live   = 1'b1;
              ram_req.wdata.parent = op_parent;
              ram_req.wdata.runs   = '0;
              free_head_next       = rdata.next;
              if (cur_is_s) begin
                cur_handle_next = new_handle;
              end
              res.handle = new_handle;
              res.slot   = s;
              res.found  = 1'b1;
            end
          end
          ghsa_pkg::MODE_FREE: begin
            if (!rdata.live) begin
              res.status = ghsa_pkg::STAT_BAD;
            end else begin
              ram_req.we         = 1'b1;
              ram_req.wdata.live = 1'b0;
              ram_req.wdata.next = free_head;
              free_head_next     = op_slot;
              res.handle = rdata.handle;
              res.slot   = s;
              res.found  = 1'b1;
            end
          end
          ghsa_pkg::MODE_LOOKUP: begin
            priority if (op_handle == '0) begin
              if (cur_slot != ghsa_pkg::NIL) begin
                res.handle = cur_handle;
                res.slot   = cur_slot[IW-1:0];
                res.found  = 1'b1;
              end
            end else if (!hit) begin
              res.status = ghsa_pkg::STAT_BAD;
            end else if (op_perm && !cur_is_s &&
                         (cur_slot == ghsa_pkg::NIL || rdata.parent != cur_handle)) begin
              res.status = ghsa_pkg::STAT_BAD;
            end else begin
              res.handle = rdata.handle;
              res.slot   = s;
              res.found  = 1'b1;
            end
          end
          ghsa_pkg::MODE_RUN: begin
            if (!hit) begin
              res.status = ghsa_pkg::STAT_BAD;
            end else begin
              ram_req.we         = 1'b1;
              ram_req.wdata.runs = rdata.runs + ghsa_pkg::RUN_W'(1);
              cur_slot_next      = op_slot;
              cur_handle_next    = rdata.handle;
              res.handle = rdata.handle;
              res.slot   = s;
              res.found  = 1'b1;
            end
          end
        endcase
      end
      default: begin
        state_next = ghsa_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghsa_pkg::*;

  // One command as it goes onto the command port
  typedef struct packed {
    mode_t               op;
    logic [HANDLE_W-1:0] hdl;
    logic [HANDLE_W-1:0] parent;
    logic                perm;
  } command_t;

  // One result as it should come back on the result port
  typedef struct packed {
    status_t               st;
    logic [HANDLE_W-1:0]   hdl;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  found;
  } outcome_t;

  // Per-slot lifecycle in the shadow table
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_t;

  localparam logic [HANDLE_W-1:0] G1 = HANDLE_W'(GEN_INC);  // first generation

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    mode = MODE_ALLOC;
  logic [HANDLE_W-1:0]           handle = '0;
  logic [HANDLE_W-1:0]           parent_handle = '0;
  logic                          check_permission = 1'b0;
  logic                          done;
  logic [1:0]                    status;
  logic [HANDLE_W-1:0]           result_handle;
  logic [SLOT_OUT_W-1:0]         result_slot;
  logic                          found_valid;

  generation_handle_slot_allocator_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .handle           (handle),
    .parent_handle    (parent_handle),
    .check_permission (check_permission),
    .done             (done),
    .status           (status),
    .result_handle    (result_handle),
    .result_slot      (result_slot),
    .found_valid      (found_valid)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Shadow slot table: what the allocator should hold after every transfer
  logic [31:0]         gen_handle [SLOTS];  // full handle incl. generation
  slot_state_t         slot_state [SLOTS];
  logic [HANDLE_W-1:0] owner      [SLOTS];  // parent recorded at allocate
  logic [31:0]         run_count  [SLOTS];
  logic [PTR_W-1:0]    free_link  [SLOTS];
  logic [PTR_W-1:0]    free_top;            // LIFO free-list head, NIL when full
  logic [PTR_W-1:0]    cur;                 // current slot, NIL when none

  command_t pending[$];     // commands waiting for the driver
  outcome_t predicted[$];   // results owed by the allocator, oldest first
  command_t on_bus;         // command currently presented with start
  int       gap_left = 0;
  bit       quiet = 1'b0;   // no idle bursts in the closing stretch
  int       n_fail = 0;
  int       n_checked = 0;
  int       op_count[4] = '{default: 0};
  int       status_seen[3] = '{default: 0};

  function automatic outcome_t slot_outcome(logic [IDX_W-1:0] s);
    return '{st: STAT_OK, hdl: gen_handle[s][HANDLE_W-1:0],
             slot: SLOT_OUT_W'(s), found: 1'b1};
  endfunction

  // Applies one transferred command to the shadow table, returns the result.
  function automatic outcome_t apply_command(command_t c);
    outcome_t         o;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] cs;
    logic [31:0]      g;
    logic             live;
    o    = '{st: STAT_OK, hdl: '0, slot: '0, found: 1'b0};
    s    = c.hdl[IDX_W-1:0];
    cs   = cur[IDX_W-1:0];
    // handle names an allocated slot of the current generation
    live = (slot_state[s] != SLOT_FREE) && (gen_handle[s] == {1'b0, c.hdl});
    case (c.op)
      MODE_ALLOC: begin
        if (free_top == NIL) begin
          o.st = STAT_FULL;
        end else begin
          s = free_top[IDX_W-1:0];
          g = (gen_handle[s] + GEN_INC) & ~32'(SLOTS - 1);
          if (g == 32'd0 || g[31]) g = GEN_INC;  // generation wrap restarts at one step
          gen_handle[s] = g | 32'(s);
          owner[s]      = c.parent;
          slot_state[s] = SLOT_RUNNABLE;
          run_count[s]  = 32'd0;
          free_top      = free_link[s];
          o = slot_outcome(s);
        end
      end
      MODE_FREE: begin
        // index part only, no generation check; current keeps pointing here
        if (slot_state[s] == SLOT_FREE) begin
          o.st = STAT_BAD;
        end else begin
          slot_state[s] = SLOT_FREE;
          free_link[s]  = free_top;
          free_top      = {1'b0, s};
          o = slot_outcome(s);
        end
      end
      MODE_LOOKUP: begin
        if (c.hdl == '0) begin
          if (cur != NIL) o = slot_outcome(cs);
        end else if (!live) begin
          o.st = STAT_BAD;
        end else if (c.perm && {1'b0, s} != cur &&
                     (cur == NIL || owner[s] != gen_handle[cs][HANDLE_W-1:0])) begin
          o.st = STAT_BAD;
        end else begin
          o = slot_outcome(s);
        end
      end
      MODE_RUN: begin
        if (!live) begin
          o.st = STAT_BAD;
        end else begin
          if (cur != NIL && slot_state[cs] == SLOT_RUNNING) slot_state[cs] = SLOT_RUNNABLE;
          cur           = {1'b0, s};
          slot_state[s] = SLOT_RUNNING;
          run_count[s]  = run_count[s] + 32'd1;
          o = slot_outcome(s);
        end
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: pick handles from the shadow table so most commands hit
  // live slots, with a share of stale and garbage handles mixed in.
  // ---------------------------------------------------------------------------
  function automatic logic [HANDLE_W-1:0] current_handle();
    return (cur == NIL) ? '0 : gen_handle[cur[IDX_W-1:0]][HANDLE_W-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] live_handle();
    int               base;
    logic [IDX_W-1:0] s;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      s = IDX_W'(base + k);
      if (slot_state[s] != SLOT_FREE) return gen_handle[s][HANDLE_W-1:0];
    end
    return HANDLE_W'($urandom);
  endfunction

  // Live slot whose recorded parent is the current slot's handle
  function automatic logic [HANDLE_W-1:0] child_handle();
    int               base;
    logic [IDX_W-1:0] s;
    if (cur != NIL) begin
      base = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        s = IDX_W'(base + k);
        if (slot_state[s] != SLOT_FREE && {1'b0, s} != cur && owner[s] == current_handle())
          return gen_handle[s][HANDLE_W-1:0];
      end
    end
    return live_handle();
  endfunction

  function automatic logic [HANDLE_W-1:0] stale_handle();
    logic [HANDLE_W-1:0] h;
    h = live_handle();
    case ($urandom_range(0, 2))
      0:       return h + G1;  // future generation
      1:       return h - G1;  // previous generation
      default: return gen_handle[IDX_W'($urandom_range(0, SLOTS - 1))][HANDLE_W-1:0];
    endcase
  endfunction

  function automatic command_t cmd(mode_t op, logic [HANDLE_W-1:0] h,
                                   logic [HANDLE_W-1:0] p, logic perm);
    return '{op: op, hdl: h, parent: p, perm: perm};
  endfunction

  function automatic command_t make_cmd(mode_t op);
    command_t c;
    int       pick;
    c = cmd(op, HANDLE_W'($urandom), HANDLE_W'($urandom), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    // children of the current slot give the permission check something to pass
    if (pick < 50) c.parent = current_handle();
    else if (pick < 75) c.parent = live_handle();
    pick = $urandom_range(0, 99);
    if (op == MODE_LOOKUP) begin
      if (pick < 15) c.hdl = '0;
      else if (pick < 40) begin
        c.hdl  = child_handle();
        c.perm = 1'b1;
      end
      else if (pick < 65) c.hdl = live_handle();
      else if (pick < 75) c.hdl = current_handle();
      else if (pick < 88) c.hdl = stale_handle();
    end else if (op != MODE_ALLOC) begin
      if (pick < 20) c.hdl = child_handle();
      else if (pick < 70) c.hdl = live_handle();
      else if (pick < 85) c.hdl = stale_handle();
    end
    return c;
  endfunction

  function automatic mode_t pick_mode(int wa, int wf, int wl);
    int r;
    r = $urandom_range(0, 99);
    if (r < wa) return MODE_ALLOC;
    if (r < wa + wf) return MODE_FREE;
    if (r < wa + wf + wl) return MODE_LOOKUP;
    return MODE_RUN;
  endfunction

  // Builds the next command only once the queue has drained, so handle
  // choice sees the table at most one transfer behind.
  task automatic feed(input mode_t op);
    while (pending.size() != 0) @(negedge clk);
    pending.push_back(make_cmd(op));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands, holds start until the transfer, and
  // updates the shadow table on each transfer. Idle bursts go between
  // commands, so start stays high through busy when back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
      for (int i = 0; i < SLOTS; i++) begin
        gen_handle[i] = '0;
        slot_state[i] = SLOT_FREE;
        owner[i]      = '0;
        run_count[i]  = '0;
        free_link[i]  = PTR_W'(i + 1);
      end
      free_top = '0;
      cur      = NIL;
    end else begin
      if (start && !busy) begin
        predicted.push_back(apply_command(on_bus));
        op_count[on_bus.op]++;
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 8);
      end
      if (start && busy) begin
        // transfer not taken yet, keep everything as is
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending.size() != 0) begin
        on_bus = pending.pop_front();
        start            <= 1'b1;
        mode             <= on_bus.op;
        handle           <= on_bus.hdl;
        parent_handle    <= on_bus.parent;
        check_permission <= on_bus.perm;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done marks a one-cycle result; it transfers at the edge that
  // ends that cycle. Compare against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (predicted.size() == 0) begin
        $error("result with nothing outstanding: status %0d handle %0h slot %0d",
               status, result_handle, result_slot);
        n_fail++;
      end else begin
        want = predicted.pop_front();
        n_checked++;
        status_seen[want.st]++;
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          n_fail++;
        end
        if (result_handle !== want.hdl) begin
          $error("result_handle: expected %0h, got %0h", want.hdl, result_handle);
          n_fail++;
        end
        if (result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, result_slot);
          n_fail++;
        end
        if (found_valid !== want.found) begin
          $error("found_valid: expected %0b, got %0b", want.found, found_valid);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed walk, random mix, fill to full, drain-heavy mix, and
  // a closing stretch at full rate.
  // ---------------------------------------------------------------------------
  initial begin
    // nothing allocated and no current slot
    pending.push_back(cmd(MODE_LOOKUP, '0, '0, 1'b0));   // lookup current: none
    pending.push_back(cmd(MODE_LOOKUP, '0, '0, 1'b1));
    pending.push_back(cmd(MODE_RUN, '0, '0, 1'b0));      // run of a free slot
    pending.push_back(cmd(MODE_FREE, G1, '0, 1'b0));     // free of a free slot
    // first allocations come off the list in index order
    pending.push_back(cmd(MODE_ALLOC, '1, '0, 1'b0));
    pending.push_back(cmd(MODE_ALLOC, '0, G1, 1'b1));
    pending.push_back(cmd(MODE_ALLOC, '0, '1, 1'b0));
    pending.push_back(cmd(MODE_LOOKUP, G1 + HANDLE_W'(1), '0, 1'b1)); // permission, no current
    pending.push_back(cmd(MODE_LOOKUP, G1 + HANDLE_W'(1), '0, 1'b0));
    pending.push_back(cmd(MODE_RUN, G1, '0, 1'b0));
    pending.push_back(cmd(MODE_LOOKUP, '0, '0, 1'b0));
    pending.push_back(cmd(MODE_LOOKUP, G1 + HANDLE_W'(1), '0, 1'b1)); // direct child
    pending.push_back(cmd(MODE_LOOKUP, G1 + HANDLE_W'(2), '0, 1'b1)); // not a child
    pending.push_back(cmd(MODE_LOOKUP, G1, '0, 1'b1));     // current itself
    pending.push_back(cmd(MODE_LOOKUP, G1 + G1 + HANDLE_W'(1), '0, 1'b0)); // wrong generation
    pending.push_back(cmd(MODE_RUN, G1 + HANDLE_W'(1), '0, 1'b0));    // demotes the old current
    pending.push_back(cmd(MODE_FREE, G1 + HANDLE_W'(1), '0, 1'b0));   // free the current slot
    pending.push_back(cmd(MODE_LOOKUP, '0, '0, 1'b1));     // still reports it
    pending.push_back(cmd(MODE_RUN, G1 + HANDLE_W'(1), '0, 1'b0));
    pending.push_back(cmd(MODE_ALLOC, '0, G1, 1'b0));      // LIFO reuse, next generation
    pending.push_back(cmd(MODE_LOOKUP, G1 + HANDLE_W'(1), '0, 1'b0)); // old handle now stale
    pending.push_back(cmd(MODE_FREE, 31'h7FFF_FC02, '0, 1'b1)); // index only, any gen
    pending.push_back(cmd(MODE_LOOKUP, '1, '1, 1'b1));
    pending.push_back(cmd(MODE_RUN, G1 + G1 + HANDLE_W'(1), '0, 1'b0));
    pending.push_back(cmd(MODE_ALLOC, '0, '1, 1'b1));

    for (int n = 0; n < 30; n++) feed(pick_mode(40, 15, 30));
    // allocate until the table is full, then a few more against a full table
    while (free_top != NIL) feed(MODE_ALLOC);
    repeat (4) feed(MODE_ALLOC);
    for (int n = 0; n < 24; n++) feed(pick_mode(15, 45, 25));
    for (int n = 0; n < 30; n++) begin
      if (n == 15) quiet = 1'b1;
      feed(pick_mode(30, 25, 30));
    end

    while (pending.size() != 0 || start) @(negedge clk);
    while (predicted.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("%0d commands: %0d allocate, %0d free, %0d lookup, %0d run",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[MODE_ALLOC], op_count[MODE_FREE], op_count[MODE_LOOKUP],
             op_count[MODE_RUN]);
    $display("%0d results checked: %0d ok, %0d table full, %0d bad or stale handle",
             n_checked, status_seen[STAT_OK], status_seen[STAT_FULL],
             status_seen[STAT_BAD]);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, well past clearing pass plus every command at its worst gap
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
